### hdl/bfei_pkg.sv
package bfei_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = 32;
    localparam int unsigned ARG_W  = 32;
    localparam int unsigned SHAMT_W = 6;
    localparam int unsigned NARROW_W = 8;

    typedef enum logic [2:0] {
        CMD_EXT_U32 = 3'd0,
        CMD_EXT_S32 = 3'd1,
        CMD_EXT_U64 = 3'd2,
        CMD_EXT_S64 = 3'd3,
        CMD_INS_32  = 3'd4,
        CMD_INS_64  = 3'd5
    } cmd_t;

    typedef struct packed {
        cmd_t                command;
        logic [WORD_W-1:0]   base;
        logic [WORD_W-1:0]   insert_value;
        logic [ARG_W-1:0]    position;
        logic [ARG_W-1:0]    length;
    } item_t;

    // Ones in the low n bits, n < 64.
    function automatic logic [WORD_W-1:0] low_mask(input logic [SHAMT_W-1:0] n);
        return ~({WORD_W{1'b1}} << n);
    endfunction

endpackage

### hdl/bfei_core.sv
module bfei_core (
    input  bfei_pkg::item_t            item,
    output logic [bfei_pkg::WORD_W-1:0] result
);

    logic                                is64;
    logic                                signed_op;
    logic [bfei_pkg::ARG_W-1:0]          p_eff;
    logic [bfei_pkg::ARG_W-1:0]          l_eff;
    logic [bfei_pkg::SHAMT_W:0]          w_eff;
    logic [bfei_pkg::SHAMT_W:0]          room;
    logic [bfei_pkg::SHAMT_W-1:0]        sh;
    logic [bfei_pkg::SHAMT_W-1:0]        sign_idx;
    logic                                pos_big;
    logic                                len_big;
    logic                                len_fills;
    logic [bfei_pkg::WORD_W-1:0]         b_src;
    logic [bfei_pkg::WORD_W-1:0]         b_zx;
    logic [bfei_pkg::WORD_W-1:0]         ins_src;
    logic                                fill;
    logic [bfei_pkg::WORD_W:0]           shr_wide;
    logic [bfei_pkg::WORD_W-1:0]         shr;
    logic [bfei_pkg::WORD_W-1:0]         lm;
    logic [bfei_pkg::WORD_W-1:0]         wm;
    logic [bfei_pkg::WORD_W-1:0]         ins_mask;
    logic [bfei_pkg::WORD_W-1:0]         ext_u_res;
    logic [bfei_pkg::WORD_W-1:0]         ext_s_res;
    logic [bfei_pkg::WORD_W-1:0]         ins_res;

    always_comb
    begin
        is64 = (item.command == bfei_pkg::CMD_EXT_U64) ||
               (item.command == bfei_pkg::CMD_EXT_S64) ||
               (item.command == bfei_pkg::CMD_INS_64);
        signed_op = (item.command == bfei_pkg::CMD_EXT_S32) ||
                    (item.command == bfei_pkg::CMD_EXT_S64);

        // 32-bit ops see only the low byte of position and length
        p_eff = is64 ? item.position
                     : {{(bfei_pkg::ARG_W-bfei_pkg::NARROW_W){1'b0}},
                        item.position[bfei_pkg::NARROW_W-1:0]};
        l_eff = is64 ? item.length
                     : {{(bfei_pkg::ARG_W-bfei_pkg::NARROW_W){1'b0}},
                        item.length[bfei_pkg::NARROW_W-1:0]};
        w_eff = is64 ? (bfei_pkg::SHAMT_W+1)'(bfei_pkg::WORD_W)
                     : (bfei_pkg::SHAMT_W+1)'(bfei_pkg::HALF_W);

        pos_big = p_eff >= bfei_pkg::ARG_W'(w_eff);
        len_big = l_eff >= bfei_pkg::ARG_W'(w_eff);
        sh      = p_eff[bfei_pkg::SHAMT_W-1:0];
        room    = w_eff - {1'b0, sh};
        len_fills = l_eff >= bfei_pkg::ARG_W'(room);

        b_zx = is64 ? item.base
                    : {{bfei_pkg::HALF_W{1'b0}}, item.base[bfei_pkg::HALF_W-1:0]};
        if (is64)
        begin
            b_src = item.base;
        end
        else
        begin
            b_src = {{bfei_pkg::HALF_W{signed_op & item.base[bfei_pkg::HALF_W-1]}},
                     item.base[bfei_pkg::HALF_W-1:0]};
        end
        ins_src = is64 ? item.insert_value
                       : {{bfei_pkg::HALF_W{1'b0}},
                          item.insert_value[bfei_pkg::HALF_W-1:0]};

        // one shared right shifter: logical for unsigned, arithmetic for signed
        fill     = signed_op & b_src[bfei_pkg::WORD_W-1];
        shr_wide = {fill, b_src};
        shr_wide = $signed(shr_wide) >>> sh;
        shr      = shr_wide[bfei_pkg::WORD_W-1:0];

        lm       = bfei_pkg::low_mask(l_eff[bfei_pkg::SHAMT_W-1:0]);
        sign_idx = l_eff[bfei_pkg::SHAMT_W-1:0] - bfei_pkg::SHAMT_W'(1);
        wm       = is64 ? {bfei_pkg::WORD_W{1'b1}}
                        : {{bfei_pkg::HALF_W{1'b0}}, {bfei_pkg::HALF_W{1'b1}}};

        if (pos_big)
            ext_u_res = '0;
        else if (len_big)
            ext_u_res = shr;
        else
            ext_u_res = shr & lm;

        // zero length wins over an out-of-range position
        if (l_eff == '0)
            ext_s_res = '0;
        else if (pos_big)
            ext_s_res = {bfei_pkg::WORD_W{b_src[bfei_pkg::WORD_W-1]}};
        else if (len_fills)
            ext_s_res = shr;
        else
            ext_s_res = (shr & lm) | (shr[sign_idx] ? ~lm : '0);
        ext_s_res = ext_s_res & wm;

        ins_mask = ((len_big ? wm : lm) << sh) & wm;
        if (pos_big)
            ins_res = b_zx & wm;
        else
            ins_res = ((~ins_mask & b_zx) | (ins_mask & (ins_src << sh))) & wm;

        case (item.command)
            bfei_pkg::CMD_EXT_U32: result = ext_u_res;
            bfei_pkg::CMD_EXT_S32: result = ext_s_res;
            bfei_pkg::CMD_EXT_U64: result = ext_u_res;
            bfei_pkg::CMD_EXT_S64: result = ext_s_res;
            bfei_pkg::CMD_INS_32:  result = ins_res;
            bfei_pkg::CMD_INS_64:  result = ins_res;
            default:               result = '0;
        endcase
    end

endmodule

### hdl/bit_field_extract_insert_unit.sv
// Path from the accepting edge to the edge that takes the result: input
//   register, one pass of field logic, result register.
// Throughput: one item every cycle; busy is never raised.
// Reset (rst_n low, asynchronous): clears the valid flags and done; payload
//   registers keep whatever they held. The receiver cannot stall done.
module bit_field_extract_insert_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    command,
    input  logic [bfei_pkg::WORD_W-1:0]   base,
    input  logic [bfei_pkg::WORD_W-1:0]   insert_value,
    input  logic [bfei_pkg::ARG_W-1:0]    position,
    input  logic [bfei_pkg::ARG_W-1:0]    length,
    output logic                          done,
    output logic [bfei_pkg::WORD_W-1:0]   result
);

    // Stage 1: captured item. Stage 2: registered result with its strobe.
    bfei_pkg::item_t                 item_reg;
    bfei_pkg::item_t                 item_next;
    logic                            valid_reg;
    logic [bfei_pkg::WORD_W-1:0]     result_reg;
    logic [bfei_pkg::WORD_W-1:0]     result_next;
    logic                            done_reg;
    logic                            accept;

    // Fully pipelined, so nothing ever holds the issuer off.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        item_next.command      = bfei_pkg::cmd_t'(command);
        item_next.base         = base;
        item_next.insert_value = insert_value;
        item_next.position     = position;
        item_next.length       = length;
    end

    // Control flags under reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
            done_reg  <= valid_reg;
        end
    end

    // Payload: no reset needed, qualified by the flags above.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
        if (valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    // Extract / insert datapath: shared shifter, masks and select.
    bfei_core u_core (
        .item   (item_reg),
        .result (result_next)
    );

    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    // Every accepted item produces a strobe once it has passed the input and result registers.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("accepted item did not complete in two cycles");

    // No strobe without an item in the input register the cycle before.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(valid_reg))
        else $error("result strobe without a captured item");

    // Unused command codes must yield zero.
    a_unused_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (item_reg.command[2:1] == 2'b11)) |=> (result == '0))
        else $error("unused command gave a nonzero result");

    // 32-bit operations always give a zero upper half.
    a_narrow_zx: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && ((item_reg.command == bfei_pkg::CMD_EXT_U32) ||
                       (item_reg.command == bfei_pkg::CMD_EXT_S32) ||
                       (item_reg.command == bfei_pkg::CMD_INS_32)))
        |=> (result[bfei_pkg::WORD_W-1:bfei_pkg::HALF_W] == '0))
        else $error("32-bit operation left upper bits set");
`endif

endmodule
